[rtl/core/fbpa_pkg.sv]
// Shared types and constants of the fixed block pool allocator.
// No dependencies; compiled first.
package fbpa_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned REG_IDX_W = 2;
  // count * size stays below 2^22
  localparam int unsigned OFFS_W    = 22;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BASE_ADDRESS = 2'd0,
    REG_BLOCK_SIZE   = 2'd1,
    REG_BLOCK_COUNT  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_STK,
    ST_ADDR,
    ST_CHECK,
    ST_DIV,
    ST_FLAG,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] quotient;
    logic               rem_zero;
  } div_res_t;

endpackage

[rtl/core/fbpa_if.sv]
// Channel interfaces of the fixed block pool allocator: command, response, config.
// Depends on fbpa_pkg.
interface fbpa_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [fbpa_pkg::CMD_W-1:0]       command;
  logic [fbpa_pkg::ADDR_W-1:0]      address;

  modport source (output valid, command, address, input ready);
  modport sink (input valid, command, address, output ready);
endinterface

interface fbpa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             status;
  logic [fbpa_pkg::ADDR_W-1:0]      block_address;
  logic                             in_use;
  logic [fbpa_pkg::COUNT_W-1:0]     free_count;
  logic                             any_free;

  modport source (output valid, status, block_address, in_use, free_count, any_free,
                  input ready);
  modport sink (input valid, status, block_address, in_use, free_count, any_free,
                output ready);
endinterface

interface fbpa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fbpa_pkg::REG_IDX_W-1:0]   reg_index;
  logic [fbpa_pkg::ADDR_W-1:0]      wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

[rtl/core/fixed_block_pool_allocator_top.sv]
// Allocate answers after a stack read and an address add, free and query after the
// 9-step divider and a flag memory read, misaligned after the divider, out of range
// after the bound check, empty pool or unused code at once. One word in flight; the
// next is taken once the response is posted. Reset and each write to a defined config
// register run a refill sweep of the stack and flag memories, taking no command word.
// Depends on fbpa_pkg, fbpa_if, fbpa_divider.
module fixed_block_pool_allocator_top #(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fbpa_cmd_if.sink          cmd_i,
  fbpa_rsp_if.source        rsp_o,
  fbpa_cfg_if.sink          cfg_i
);

  localparam int unsigned IDX_W   = $clog2(MAX_BLOCKS);
  localparam int unsigned DEPTH_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ADDR_W  = fbpa_pkg::ADDR_W;
  localparam int unsigned SIZE_W  = fbpa_pkg::SIZE_W;
  localparam int unsigned COUNT_W = fbpa_pkg::COUNT_W;
  localparam int unsigned CMD_W   = fbpa_pkg::CMD_W;
  localparam int unsigned OFFS_W  = fbpa_pkg::OFFS_W;
  localparam int unsigned PROD_W  = IDX_W + SIZE_W;

  fbpa_pkg::state_e     state_q, state_d;
  logic [DEPTH_W-1:0]   depth_q, depth_d;
  logic [IDX_W-1:0]     sweep_q, sweep_d;
  logic [ADDR_W-1:0]    base_q;
  logic [SIZE_W-1:0]    size_q;
  logic [COUNT_W-1:0]   count_q;
  logic [OFFS_W-1:0]    span_q;

  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [ADDR_W-1:0]    offset_q, offset_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic                 status_q, status_d;
  logic [ADDR_W-1:0]    baddr_q, baddr_d;
  logic                 hit_q, hit_d;

  logic                 rsp_valid_q, rsp_valid_d;
  logic                 rsp_status_q, rsp_status_d;
  logic [ADDR_W-1:0]    rsp_baddr_q, rsp_baddr_d;
  logic                 rsp_in_use_q, rsp_in_use_d;
  logic [COUNT_W-1:0]   rsp_free_q, rsp_free_d;
  logic                 rsp_any_q, rsp_any_d;

  logic [IDX_W-1:0]     stack_mem [MAX_BLOCKS];
  logic                 flag_mem [MAX_BLOCKS];
  logic                 stk_we, flag_we, flag_wdata;
  logic [IDX_W-1:0]     stk_waddr, stk_wdata, stk_raddr, stk_rdata_q;
  logic [IDX_W-1:0]     flag_waddr, flag_raddr;
  logic                 flag_rdata_q;

  logic                 div_start;
  fbpa_pkg::div_res_t   div_res;

  logic [SIZE_W-1:0]    eff_size;
  logic [COUNT_W-1:0]   eff_cnt;
  logic                 cmd_acc, cfg_acc;

  assign eff_size = (size_q == '0) ? SIZE_W'(1) : size_q;
  assign eff_cnt  = (32'(count_q) > 32'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : count_q;

  assign cmd_i.ready = (state_q == fbpa_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign cmd_acc     = cmd_i.valid & cmd_i.ready;
  assign cfg_acc     = cfg_i.valid & cfg_i.ready;

  fbpa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (offset_q[OFFS_W-1:0]),
    .divisor_i  (eff_size),
    .res_o      (div_res)
  );

  always_comb begin
    state_d      = state_q;
    depth_d      = depth_q;
    sweep_d      = sweep_q;
    cmd_d        = cmd_q;
    offset_d     = offset_q;
    idx_d        = idx_q;
    prod_d       = prod_q;
    status_d     = status_q;
    baddr_d      = baddr_q;
    hit_d        = hit_q;
    rsp_valid_d  = rsp_valid_q & ~rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_baddr_d  = rsp_baddr_q;
    rsp_in_use_d = rsp_in_use_q;
    rsp_free_d   = rsp_free_q;
    rsp_any_d    = rsp_any_q;
    stk_we       = 1'b0;
    stk_waddr    = '0;
    stk_wdata    = '0;
    stk_raddr    = IDX_W'(depth_q - DEPTH_W'(1));
    flag_we      = 1'b0;
    flag_waddr   = '0;
    flag_wdata   = 1'b0;
    flag_raddr   = IDX_W'(div_res.quotient);
    div_start    = 1'b0;

    case (state_q)
      fbpa_pkg::ST_SWEEP: begin
        stk_we     = 1'b1;
        stk_waddr  = sweep_q;
        stk_wdata  = sweep_q;
        flag_we    = 1'b1;
        flag_waddr = sweep_q;
        sweep_d    = sweep_q + IDX_W'(1);
        if (sweep_q == IDX_W'(MAX_BLOCKS - 1)) begin
          depth_d = DEPTH_W'(eff_cnt);
          state_d = fbpa_pkg::ST_IDLE;
        end
      end
      fbpa_pkg::ST_IDLE: begin
        if (cmd_acc) begin
          cmd_d    = cmd_i.command;
          offset_d = cmd_i.address - base_q;
          status_d = 1'b1;
          baddr_d  = '0;
          hit_d    = 1'b0;
          case (cmd_i.command)
            fbpa_pkg::CMD_ALLOC: begin
              if (depth_q != '0) begin
                depth_d = depth_q - DEPTH_W'(1);
                state_d = fbpa_pkg::ST_STK;
              end else begin
                state_d = fbpa_pkg::ST_DONE;
              end
            end
            fbpa_pkg::CMD_FREE,
            fbpa_pkg::CMD_QUERY: state_d = fbpa_pkg::ST_CHECK;
            default: state_d = fbpa_pkg::ST_DONE;
          endcase
        end
      end
      fbpa_pkg::ST_STK: begin
        flag_we    = 1'b1;
        flag_waddr = stk_rdata_q;
        flag_wdata = 1'b1;
        prod_d     = PROD_W'(stk_rdata_q) * PROD_W'(eff_size);
        state_d    = fbpa_pkg::ST_ADDR;
      end
      fbpa_pkg::ST_ADDR: begin
        baddr_d  = base_q + ADDR_W'(prod_q);
        status_d = 1'b0;
        state_d  = fbpa_pkg::ST_DONE;
      end
      fbpa_pkg::ST_CHECK: begin
        if (offset_q >= ADDR_W'(span_q)) begin
          state_d = fbpa_pkg::ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = fbpa_pkg::ST_DIV;
        end
      end
      fbpa_pkg::ST_DIV: begin
        if (div_res.done) begin
          if (!div_res.rem_zero) begin
            state_d = fbpa_pkg::ST_DONE;
          end else begin
            idx_d   = IDX_W'(div_res.quotient);
            state_d = fbpa_pkg::ST_FLAG;
          end
        end
      end
      fbpa_pkg::ST_FLAG: begin
        if (cmd_q == fbpa_pkg::CMD_FREE) begin
          if (flag_rdata_q && (depth_q < DEPTH_W'(MAX_BLOCKS))) begin
            flag_we    = 1'b1;
            flag_waddr = idx_q;
            stk_we     = 1'b1;
            stk_waddr  = IDX_W'(depth_q);
            stk_wdata  = idx_q;
            depth_d    = depth_q + DEPTH_W'(1);
            status_d   = 1'b0;
          end
        end else begin
          status_d = 1'b0;
          hit_d    = flag_rdata_q;
        end
        state_d = fbpa_pkg::ST_DONE;
      end
      fbpa_pkg::ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = status_q;
          rsp_baddr_d  = baddr_q;
          rsp_in_use_d = hit_q;
          rsp_free_d   = COUNT_W'(depth_q);
          rsp_any_d    = (depth_q != '0);
          state_d      = fbpa_pkg::ST_IDLE;
        end
      end
      default: state_d = fbpa_pkg::ST_IDLE;
    endcase

    // a write to any defined register refills the pool
    if (cfg_acc && (cfg_i.reg_index <= fbpa_pkg::REG_BLOCK_COUNT)) begin
      state_d = fbpa_pkg::ST_SWEEP;
      sweep_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbpa_pkg::ST_SWEEP;
      depth_q     <= '0;
      sweep_q     <= '0;
      rsp_valid_q <= 1'b0;
      base_q      <= '0;
      size_q      <= SIZE_W'(16);
      count_q     <= COUNT_W'(256);
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      sweep_q     <= sweep_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_acc) begin
        case (cfg_i.reg_index)
          fbpa_pkg::REG_BASE_ADDRESS: base_q  <= cfg_i.wdata;
          fbpa_pkg::REG_BLOCK_SIZE:   size_q  <= cfg_i.wdata[SIZE_W-1:0];
          fbpa_pkg::REG_BLOCK_COUNT:  count_q <= cfg_i.wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    span_q       <= OFFS_W'(eff_cnt) * OFFS_W'(eff_size);
    cmd_q        <= cmd_d;
    offset_q     <= offset_d;
    idx_q        <= idx_d;
    prod_q       <= prod_d;
    status_q     <= status_d;
    baddr_q      <= baddr_d;
    hit_q        <= hit_d;
    rsp_status_q <= rsp_status_d;
    rsp_baddr_q  <= rsp_baddr_d;
    rsp_in_use_q <= rsp_in_use_d;
    rsp_free_q   <= rsp_free_d;
    rsp_any_q    <= rsp_any_d;
  end

  // free-index stack
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_q <= stack_mem[stk_raddr];
  end

  // in-use flags
  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    flag_rdata_q <= flag_mem[flag_raddr];
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.block_address = rsp_baddr_q;
  assign rsp_o.in_use        = rsp_in_use_q;
  assign rsp_o.free_count    = rsp_free_q;
  assign rsp_o.any_free      = rsp_any_q;

endmodule

[rtl/core/fbpa_divider.sv]
// Restoring divider: block offset by block size, one quotient bit per cycle.
// Depends on fbpa_pkg.
module fbpa_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fbpa_pkg::OFFS_W-1:0]   dividend_i,
  input  logic [fbpa_pkg::SIZE_W-1:0]   divisor_i,
  output fbpa_pkg::div_res_t            res_o
);

  localparam int unsigned QW     = fbpa_pkg::COUNT_W;
  localparam int unsigned OW     = fbpa_pkg::OFFS_W;
  localparam int unsigned STEP_W = $clog2(QW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [OW-1:0]     rem_q, rem_d;
  logic [OW-1:0]     dsr_q, dsr_d;
  logic [QW-1:0]     quo_q, quo_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(QW - 1);
      rem_d  = dividend_i;
      dsr_d  = OW'(divisor_i) << (QW - 1);
      quo_d  = '0;
    end else if (busy_q) begin
      if (rem_q >= dsr_q) begin
        rem_d = rem_q - dsr_q;
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      dsr_d = dsr_q >> 1;
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign res_o.done     = done_q;
  assign res_o.quotient = quo_q;
  assign res_o.rem_zero = (rem_q == '0);

endmodule

[rtl/core/fbpa_checker.sv]
// Port-level assertions for the fixed block pool allocator, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator_top.
module fbpa_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cmd_ready_i,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_i,
  input logic [fbpa_pkg::REG_IDX_W-1:0]   cfg_reg_index_i,
  input logic                             rsp_valid_i,
  input logic                             rsp_ready_i,
  input logic                             rsp_status_i,
  input logic [fbpa_pkg::ADDR_W-1:0]      rsp_block_address_i,
  input logic                             rsp_in_use_i,
  input logic [fbpa_pkg::COUNT_W-1:0]     rsp_free_count_i,
  input logic                             rsp_any_free_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_block_address_i)
      && $stable(rsp_free_count_i))
    else $error("response word changed while stalled");

  a_any_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_any_free_i == (rsp_free_count_i != '0)))
    else $error("any_free disagrees with free_count");

  a_addr_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_block_address_i != '0) |-> !rsp_status_i && !rsp_in_use_i)
    else $error("block address on a failed or query response");

  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_in_use_i |-> !rsp_status_i)
    else $error("in_use set on a failed response");

  a_cfg_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_i && (cfg_reg_index_i <= fbpa_pkg::REG_BLOCK_COUNT)
      |=> !cmd_ready_i)
    else $error("command accepted during refill");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .cmd_ready_i         (cmd_i.ready),
  .cfg_valid_i         (cfg_i.valid),
  .cfg_ready_i         (cfg_i.ready),
  .cfg_reg_index_i     (cfg_i.reg_index),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_status_i        (rsp_o.status),
  .rsp_block_address_i (rsp_o.block_address),
  .rsp_in_use_i        (rsp_o.in_use),
  .rsp_free_count_i    (rsp_o.free_count),
  .rsp_any_free_i      (rsp_o.any_free)
);

[tb/tb.sv]
// Self-checking testbench for fixed_block_pool_allocator_top: directed corner words,
// a back-pressure run and randomized pool settings, checked against a local pool predictor.
// Depends on fbpa_pkg, the fbpa_*_if interfaces and the allocator RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ADDR_W        = fbpa_pkg::ADDR_W;
  localparam int unsigned SIZE_W        = fbpa_pkg::SIZE_W;
  localparam int unsigned COUNT_W       = fbpa_pkg::COUNT_W;
  localparam int unsigned CMD_W         = fbpa_pkg::CMD_W;
  localparam int unsigned REG_IDX_W     = fbpa_pkg::REG_IDX_W;
  localparam int unsigned MAX_BLOCKS    = 256;
  localparam int unsigned TOTAL_WORDS   = 1450;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic               status;
    logic [ADDR_W-1:0]  block_address;
    logic               in_use;
    logic [COUNT_W-1:0] free_count;
    logic               any_free;
  } pool_reply_t;

  logic clk_i;
  logic rst_ni;

  fbpa_cmd_if cmd_ch();
  fbpa_rsp_if rsp_ch();
  fbpa_cfg_if cfg_ch();

  fixed_block_pool_allocator_top #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  // predicted pool state
  logic [ADDR_W-1:0]  pool_base;
  logic [SIZE_W-1:0]  pool_size_reg;
  logic [COUNT_W-1:0] pool_count_reg;
  logic [7:0]         free_stack_q [MAX_BLOCKS];
  bit                 in_use_map [MAX_BLOCKS];
  int unsigned        stack_top;

  pool_reply_t replies_due[$];
  pool_reply_t want_reply;

  int unsigned fail_count;
  int unsigned replies_checked;
  int unsigned words_sent;
  int unsigned n_alloc, n_free, n_query, n_unused;
  int unsigned reg_writes;
  int unsigned rsp_hold_cycles;
  bit          send_burst;
  bit          rsp_burst;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned eff_size();
    return (pool_size_reg == '0) ? 1 : int'(pool_size_reg);
  endfunction

  function automatic int unsigned eff_count();
    return (pool_count_reg > MAX_BLOCKS) ? MAX_BLOCKS : int'(pool_count_reg);
  endfunction

  function automatic logic [ADDR_W-1:0] block_addr(input int unsigned idx);
    return pool_base + ADDR_W'(idx * eff_size());
  endfunction

  function automatic void pool_refill();
    int unsigned n;
    n = eff_count();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      in_use_map[i]   = 1'b0;
      free_stack_q[i] = (i < n) ? 8'(i) : 8'd0;
    end
    stack_top = n;
  endfunction

  function automatic bit locate_block(input logic [ADDR_W-1:0] addr, output int unsigned idx);
    logic [ADDR_W-1:0] offset;
    longint unsigned   sz;
    longint unsigned   span;
    sz     = eff_size();
    offset = addr - pool_base;
    span   = longint'(eff_count()) * sz;
    idx    = 0;
    if (offset >= span) return 1'b0;
    if ((offset % sz) != 0) return 1'b0;
    idx = 32'(offset / sz);
    return idx < MAX_BLOCKS;
  endfunction

  function automatic pool_reply_t apply_pool_op(input logic [CMD_W-1:0] op,
                                                input logic [ADDR_W-1:0] addr);
    pool_reply_t r;
    int unsigned idx;
    r        = '0;
    r.status = 1'b1;
    if (op == fbpa_pkg::CMD_ALLOC) begin
      if (stack_top > 0) begin
        stack_top--;
        idx              = 32'(free_stack_q[stack_top]);
        in_use_map[idx]  = 1'b1;
        r.block_address  = block_addr(idx);
        r.status         = 1'b0;
      end
    end else if (op == fbpa_pkg::CMD_FREE) begin
      if (locate_block(addr, idx) && in_use_map[idx] && stack_top < MAX_BLOCKS) begin
        in_use_map[idx]         = 1'b0;
        free_stack_q[stack_top] = 8'(idx);
        stack_top++;
        r.status = 1'b0;
      end
    end else if (op == fbpa_pkg::CMD_QUERY) begin
      if (locate_block(addr, idx)) begin
        r.status = 1'b0;
        r.in_use = in_use_map[idx];
      end
    end
    r.free_count = COUNT_W'(stack_top);
    r.any_free   = (stack_top != 0);
    return r;
  endfunction

  // address of a block in use, or of any block when none is
  function automatic logic [ADDR_W-1:0] pick_allocated();
    int unsigned used_idx[$];
    int unsigned n;
    n = eff_count();
    for (int i = 0; i < MAX_BLOCKS; i++)
      if (in_use_map[i]) used_idx.push_back(i);
    if (used_idx.size() == 0) return block_addr($urandom_range(0, (n > 0) ? n - 1 : 0));
    return block_addr(used_idx[$urandom_range(0, used_idx.size() - 1)]);
  endfunction

  function automatic void check_field(input string name, input logic [ADDR_W-1:0] exp_v,
                                      input logic [ADDR_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (replies_due.size() == 0) begin
        $error("reply word with nothing pending");
        fail_count++;
      end else begin
        want_reply = replies_due.pop_front();
        replies_checked++;
        check_field("status", ADDR_W'(want_reply.status), ADDR_W'(rsp_ch.status));
        check_field("block_address", want_reply.block_address, rsp_ch.block_address);
        check_field("in_use", ADDR_W'(want_reply.in_use), ADDR_W'(rsp_ch.in_use));
        check_field("free_count", ADDR_W'(want_reply.free_count),
                    ADDR_W'(rsp_ch.free_count));
        check_field("any_free", ADDR_W'(want_reply.any_free), ADDR_W'(rsp_ch.any_free));
      end
    end
  end

  // reply side: random stalls, burst stretches, and a long hold on request
  initial begin : reply_sink
    int unsigned stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = rsp_burst ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
      if (rsp_hold_cycles > 0) begin
        stall           = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= op;
    cmd_ch.address <= addr;
    do @(posedge clk_i); while (!cmd_ch.ready);
    replies_due.push_back(apply_pool_op(op, addr));
    words_sent++;
    case (op)
      fbpa_pkg::CMD_ALLOC: n_alloc++;
      fbpa_pkg::CMD_FREE:  n_free++;
      fbpa_pkg::CMD_QUERY: n_query++;
      default:             n_unused++;
    endcase
  endtask

  task automatic drain_pool();
    cmd_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // leaves valid high so back-to-back writes need no re-arm; callers lower it
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      fbpa_pkg::REG_BASE_ADDRESS: pool_base      = data;
      fbpa_pkg::REG_BLOCK_SIZE:   pool_size_reg  = data[SIZE_W-1:0];
      fbpa_pkg::REG_BLOCK_COUNT:  pool_count_reg = data[COUNT_W-1:0];
      default: ;
    endcase
    if (idx != REG_UNUSED) pool_refill();
    reg_writes++;
  endtask

  task automatic apply_config(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size,
                              input logic [ADDR_W-1:0] count);
    drain_pool();
    write_reg(fbpa_pkg::REG_BASE_ADDRESS, base);
    write_reg(fbpa_pkg::REG_BLOCK_SIZE, size);
    write_reg(fbpa_pkg::REG_BLOCK_COUNT, count);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_default_pool();
    send_cmd(fbpa_pkg::CMD_QUERY, 32'h0000_0000);
    send_cmd(fbpa_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
    send_cmd(fbpa_pkg::CMD_QUERY, 32'h0000_0FF0);
    send_cmd(fbpa_pkg::CMD_QUERY, 32'h0000_1000);   // exclusive end bound
    send_cmd(fbpa_pkg::CMD_QUERY, 32'h0000_0FF8);   // misaligned
    send_cmd(fbpa_pkg::CMD_FREE, 32'h0000_0000);    // not in use
    send_cmd(CMD_UNUSED, 32'hFFFF_FFFF);
    send_cmd(fbpa_pkg::CMD_FREE, 32'h0000_0FF0);
    send_cmd(fbpa_pkg::CMD_FREE, 32'h0000_0FF0);
  endtask

  task automatic test_config_corners();
    // wrapping block addresses, then an empty stack
    apply_config(32'hFFFF_FFF0, 32'd8, 32'd4);
    repeat (5) send_cmd(fbpa_pkg::CMD_ALLOC, $urandom());
    send_cmd(fbpa_pkg::CMD_QUERY, 32'h0000_0000);
    send_cmd(fbpa_pkg::CMD_FREE, 32'hFFFF_FFF8);
    // size zero acts as one byte, count saturates
    apply_config(32'h0000_0100, 32'hFFFF_E000, 32'h0000_FFFF);
    send_cmd(fbpa_pkg::CMD_ALLOC, $urandom());
    send_cmd(fbpa_pkg::CMD_QUERY, 32'h0000_01FF);
    send_cmd(fbpa_pkg::CMD_FREE, 32'h0000_0200);
    // write to a missing register must not refill
    drain_pool();
    write_reg(REG_UNUSED, $urandom());
    cfg_ch.valid <= 1'b0;
    send_cmd(fbpa_pkg::CMD_QUERY, 32'h0000_01FF);
    // oversize blocks
    apply_config(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FE02);
    repeat (3) send_cmd(fbpa_pkg::CMD_ALLOC, $urandom());
    // empty pool
    apply_config(32'h7000_0000, 32'd4096, 32'd0);
    send_cmd(fbpa_pkg::CMD_ALLOC, $urandom());
    send_cmd(fbpa_pkg::CMD_FREE, 32'h7000_0000);
    apply_config(32'h8000_0000, 32'd4096, 32'd1);
    send_cmd(fbpa_pkg::CMD_ALLOC, $urandom());
    send_cmd(fbpa_pkg::CMD_FREE, 32'h8000_0000);
  endtask

  task automatic test_backpressure();
    bit saved_burst;
    apply_config(32'h0000_0000, 32'd32, 32'd8);
    saved_burst     = send_burst;
    send_burst      = 1'b1;
    rsp_hold_cycles = HOLD_CYCLES;
    repeat (10) send_cmd(fbpa_pkg::CMD_ALLOC, $urandom());
    for (int i = 0; i < 8; i++) send_cmd(fbpa_pkg::CMD_FREE, 32'(i * 32));
    repeat (4) send_cmd(fbpa_pkg::CMD_QUERY, pick_allocated());
    send_burst = saved_burst;
  endtask

  task automatic test_random_pools();
    logic [ADDR_W-1:0] base, size, count, a;
    int unsigned       n, sz, r, phase_len;
    while (words_sent < TOTAL_WORDS) begin
      case ($urandom_range(0, 3))
        0:       base = '0;
        1:       base = 32'hFFFF_FFFF - $urandom_range(0, 4096);
        default: base = $urandom();
      endcase
      case ($urandom_range(0, 9))
        0:       size = 0;
        1:       size = 4096;
        2:       size = $urandom_range(4097, 8191);
        3:       size = 1;
        default: size = $urandom_range(2, 64);
      endcase
      case ($urandom_range(0, 11))
        0:       count = 0;
        1:       count = 256;
        2:       count = $urandom_range(257, 511);
        3:       count = 1;
        default: count = $urandom_range(2, 24);
      endcase
      if ($urandom_range(0, 3) == 0) size = ($urandom() & ~32'h1FFF) | size;
      if ($urandom_range(0, 3) == 0) count = ($urandom() & ~32'h1FF) | count;
      apply_config(base, size, count);
      n         = eff_count();
      sz        = eff_size();
      phase_len = $urandom_range(40, 120);
      for (int k = 0; k < phase_len && words_sent < TOTAL_WORDS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          send_cmd(fbpa_pkg::CMD_ALLOC, $urandom());
        end else if (r < 62) begin
          send_cmd(fbpa_pkg::CMD_FREE, pick_allocated());
        end else if (r < 75) begin
          a = $urandom_range(0, 1) ? pick_allocated()
                                   : block_addr($urandom_range(0, (n > 0) ? n - 1 : 0));
          send_cmd(fbpa_pkg::CMD_QUERY, a);
        end else if (r < 82) begin
          send_cmd(fbpa_pkg::CMD_FREE, block_addr($urandom_range(0, (n > 0) ? n - 1 : 0)));
        end else if (r < 90) begin
          case ($urandom_range(0, 2))
            0:       a = block_addr(n);
            1:       a = pool_base - sz;
            default: a = block_addr($urandom_range(0, (n > 0) ? n - 1 : 0))
                         + ((sz > 1) ? $urandom_range(1, sz - 1) : sz * n);
          endcase
          send_cmd($urandom_range(0, 1) ? fbpa_pkg::CMD_FREE : fbpa_pkg::CMD_QUERY, a);
        end else if (r < 95) begin
          send_cmd($urandom_range(0, 1) ? fbpa_pkg::CMD_FREE : fbpa_pkg::CMD_QUERY,
                   $urandom());
        end else begin
          send_cmd(CMD_UNUSED, $urandom());
        end
      end
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.command   <= fbpa_pkg::CMD_ALLOC;
    cmd_ch.address   <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= fbpa_pkg::REG_BASE_ADDRESS;
    cfg_ch.wdata     <= '0;
    pool_base      = '0;
    pool_size_reg  = SIZE_W'(16);
    pool_count_reg = COUNT_W'(256);
    pool_refill();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_default_pool();
    test_config_corners();
    test_backpressure();
    test_random_pools();
    drain_pool();

    $display("Checked %0d replies to %0d words: %0d allocate, %0d free, %0d query, %0d unused",
             replies_checked, words_sent, n_alloc, n_free, n_query, n_unused);
    $display("Pool settings came from %0d register writes, incl. empty, wrapping and oversize",
             reg_writes);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
